// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_WB,
    S_DREAD,
    S_DSHOW
  } sha_state_e;

  typedef logic [31:0] word_t;

  localparam word_t OneBit  = 32'h8000_0000;
  localparam int    HashCnt = 8;

  function automatic word_t init_h(logic [2:0] i);
    word_t r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      3'd7:    r = 32'h5be0cd19;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(logic [5:0] t);
    word_t r;
    case (t)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sha_in_if.sv =====
`timescale 1ns / 1ps
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [5:0]  valid_bits;
  logic        last_word;

  modport source (output valid, data_word, valid_bits, last_word, input ready);
  modport sink   (input valid, data_word, valid_bits, last_word, output ready);
endinterface

// ===== src/sha_out_if.sv =====
`timescale 1ns / 1ps
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// ===== src/sha_ram.sv =====
`timescale 1ns / 1ps
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/sha256_hash_core_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | fields                               | beat
// in_i    | in  | data_word, valid_bits, last_word     | valid && ready
// out_o   | out | digest_word, digest_last             | valid && ready
//
// A word is taken on each in_i beat; the 16th word of a block starts a compression:
// the hash is loaded from the hash RAM, then 64 rounds, then the hash is written back.
// A last word adds padding (one a cycle, paused to compress), then 8 digest beats.
// Reset is asynchronous; the hash RAM needs no clearing, a flag marks it as initial.
// in_i.ready is low while compressing, padding or sending the digest.
module sha256_hash_core_unit (
  input logic       clk_i,
  input logic       rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  sha_state_e  state_q, state_d;
  logic [3:0]  wib_q, wib_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic        fresh_q, fresh_d;
  logic        pend_one_q, pend_one_d;
  logic        in_pad_q, in_pad_d;
  logic        hi_done_q, hi_done_d;
  logic        final_q, final_d;
  word_t       win_q [16];
  word_t       win_d [16];
  word_t       v_q [8];
  word_t       v_d [8];

  logic        push;
  word_t       push_word;
  logic        ram_we, ram_re;
  logic [2:0]  ram_waddr, ram_raddr;
  word_t       ram_wdata, ram_rdata;
  logic [2:0]  idx;
  word_t       hsel;
  logic [5:0]  vbc;
  word_t       w_t, t1, t2;

  sha_ram #(.Width(32), .Depth(HashCnt)) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx  = 3'(cnt_q - 4'd1);
  assign hsel = fresh_q ? init_h(idx) : ram_rdata;
  assign vbc  = (in_i.valid_bits > 6'd32) ? 6'd32 : in_i.valid_bits;

  assign w_t = (rnd_q < 6'd16) ? win_q[0]
             : ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
  assign t1  = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
             + round_k(rnd_q) + w_t;
  assign t2  = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_DSHOW);
  assign out_o.digest_word = ram_rdata;
  assign out_o.digest_last = (cnt_q == 4'd7);

  always_comb begin
    state_d    = state_q;
    wib_d      = wib_q;
    rnd_d      = rnd_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    fresh_d    = fresh_q;
    pend_one_d = pend_one_q;
    in_pad_d   = in_pad_q;
    hi_done_d  = hi_done_q;
    final_d    = final_q;
    win_d      = win_q;
    v_d        = v_q;
    push       = 1'b0;
    push_word  = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx;
    ram_raddr  = cnt_q[2:0];
    ram_wdata  = hsel + v_q[idx];

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          push = 1'b1;
          if (!in_i.last_word) begin
            len_d     = len_q + 64'd32;
            push_word = in_i.data_word;
            state_d   = S_IDLE;
          end else begin
            len_d      = len_q + 64'(vbc);
            in_pad_d   = 1'b1;
            hi_done_d  = 1'b0;
            pend_one_d = (vbc == 6'd32);
            if (vbc == 6'd32) begin
              push_word = in_i.data_word;
            end else begin
              push_word = (in_i.data_word & ~(32'hffff_ffff >> vbc)) | (OneBit >> vbc);
            end
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        push = 1'b1;
        if (pend_one_q) begin
          push_word  = OneBit;
          pend_one_d = 1'b0;
        end else if (!hi_done_q) begin
          if (wib_q == 4'd14) begin
            push_word = len_q[63:32];
            hi_done_d = 1'b1;
          end else begin
            push_word = '0;
          end
        end else begin
          push_word = len_q[31:0];
          final_d   = 1'b1;
        end
      end
      S_LOAD: begin
        ram_re = (cnt_q < 4'd8);
        if (cnt_q != 4'd0) begin
          v_d[idx] = hsel;
        end
        if (cnt_q == 4'd8) begin
          state_d = S_ROUND;
          rnd_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = w_t;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_WB;
          cnt_d   = '0;
        end
      end
      S_WB: begin
        ram_re = (cnt_q < 4'd8);
        ram_we = (cnt_q != 4'd0);
        if (cnt_q == 4'd8) begin
          fresh_d = 1'b0;
          cnt_d   = '0;
          if (final_q) begin
            state_d = S_DREAD;
          end else if (in_pad_q) begin
            state_d = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_DREAD: begin
        ram_re  = 1'b1;
        state_d = S_DSHOW;
      end
      S_DSHOW: begin
        if (out_o.ready) begin
          if (cnt_q == 4'd7) begin
            state_d  = S_IDLE;
            fresh_d  = 1'b1;
            len_d    = '0;
            final_d  = 1'b0;
            in_pad_d = 1'b0;
            cnt_d    = '0;
          end else begin
            cnt_d   = cnt_q + 4'd1;
            state_d = S_DREAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = push_word;
      wib_d     = wib_q + 4'd1;
      if (wib_q == 4'd15) begin
        state_d = S_LOAD;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wib_q      <= '0;
      rnd_q      <= '0;
      cnt_q      <= '0;
      len_q      <= '0;
      fresh_q    <= 1'b1;
      pend_one_q <= 1'b0;
      in_pad_q   <= 1'b0;
      hi_done_q  <= 1'b0;
      final_q    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      wib_q      <= wib_d;
      rnd_q      <= rnd_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      fresh_q    <= fresh_d;
      pend_one_q <= pend_one_d;
      in_pad_q   <= in_pad_d;
      hi_done_q  <= hi_done_d;
      final_q    <= final_d;
      v_q        <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end
endmodule

// ===== src/sha_checker.sv =====
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_word_i,
  input logic        out_last_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input taken during digest");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled digest beat changed");

  a_end_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i && in_ready_i)
    else $error("core not idle after digest");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> !out_valid_i)
    else $error("digest without last word");
endmodule

bind sha256_hash_core_unit sha_checker u_sha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_word),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.digest_word),
  .out_last_i  (out_o.digest_last)
);
